// ----- hw/rtl/crc8rx_pkg.sv -----
// Shared types, constants and register codes for the CRC-8 frame receiver.
package crc8rx_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned PhaseCount = 4;
  localparam int unsigned IdxW       = $clog2(FrameBytes);
  localparam int unsigned FillW      = IdxW + 1;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 40;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStartMarker = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgVersion     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPhaseMasks  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStatusMask  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTimeout     = 3'd4;

  // Reset values
  localparam logic [15:0] RstStartMarker = 16'hAA55;
  localparam logic [7:0]  RstVersion     = 8'd2;
  localparam logic [31:0] RstPhaseMasks  = 32'hFFFF_FFFF;
  localparam logic [7:0]  RstStatusMask  = 8'h00;
  localparam logic [31:0] RstTimeout     = 32'd500;

  localparam logic [7:0] CrcPoly = 8'h07;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrCrc      = 3'd1,
    ErrVersion  = 3'd2,
    ErrPhase    = 3'd3,
    ErrReserved = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    StIdle,
    StTick,
    StCheck,
    StDrop,
    StAlign,
    StCrc,
    StEval,
    StDone
  } state_e;

  typedef struct packed {
    logic capture;      // take the input word
    logic tick;         // run the watchdog check
    logic drop;         // drop the head byte of the window
    logic align_shift;  // drop the head byte during resync scan
    logic crc_step;     // fold one frame byte into the CRC
    logic eval;         // judge the full frame
    logic publish;      // load the result into the output register
  } cmd_t;

  typedef struct packed {
    logic full;         // window holds a whole frame
    logic marker_ok;    // window opens with both sync bytes
    logic align_done;   // window empty or head is the first sync byte
    logic crc_last;     // last CRC byte being folded in
    logic frame_bad;    // checked frame has an error
    logic out_free;     // output register can take a result
  } status_t;

endpackage

// ----- hw/rtl/crc8rx_ctrl.sv -----
// Sequencer for the frame receiver: steps the datapath through each word.
module crc8rx_ctrl
  import crc8rx_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_tick_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = in_tick_i ? StTick : StCheck;
        end
      end
      StTick:  state_d = StDone;
      StCheck: begin
        if (!status_i.full) begin
          state_d = StAlign;
        end else if (!status_i.marker_ok) begin
          state_d = StDrop;
        end else begin
          state_d = StCrc;
        end
      end
      StDrop:  state_d = StAlign;
      StAlign: begin
        if (status_i.align_done) begin
          state_d = StDone;
        end
      end
      StCrc: begin
        if (status_i.crc_last) begin
          state_d = StEval;
        end
      end
      StEval:  state_d = status_i.frame_bad ? StDrop : StDone;
      StDone: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StTick:  cmd_o.tick        = 1'b1;
      StDrop:  cmd_o.drop        = 1'b1;
      StAlign: cmd_o.align_shift = !status_i.align_done;
      StCrc:   cmd_o.crc_step    = 1'b1;
      StEval:  cmd_o.eval        = 1'b1;
      StDone:  cmd_o.publish     = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- hw/rtl/crc8rx_dp.sv -----
// Datapath: config registers, byte window, CRC, frame checks, watchdog, result register.
module crc8rx_dp
  import crc8rx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input word
  input  logic                in_tick_i,
  input  logic [7:0]          in_byte_i,
  input  logic [31:0]         in_now_i,
  // result word
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  // sequencer
  input  cmd_t                cmd_i,
  output status_t             status_o
);

  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // configuration
  logic [15:0] marker_q;
  logic [7:0]  version_q;
  logic [31:0] ph_masks_q;
  logic [7:0]  st_mask_q;
  logic [31:0] timeout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q   <= RstStartMarker;
      version_q  <= RstVersion;
      ph_masks_q <= RstPhaseMasks;
      st_mask_q  <= RstStatusMask;
      timeout_q  <= RstTimeout;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgStartMarker: marker_q   <= cfg_data_i[15:0];
        CfgVersion:     version_q  <= cfg_data_i[7:0];
        CfgPhaseMasks:  ph_masks_q <= cfg_data_i;
        CfgStatusMask:  st_mask_q  <= cfg_data_i[7:0];
        CfgTimeout:     timeout_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [7:0] sof1, sof2;
  assign sof1 = marker_q[15:8];
  assign sof2 = marker_q[7:0];

  // window
  logic [7:0]      win_q [FrameBytes];
  logic [FillW-1:0] fill_q, fill_d;
  logic [IdxW-1:0]  wr_idx;
  logic             append;
  logic             shift;

  assign append = cmd_i.capture && !in_tick_i;
  assign shift  = cmd_i.drop || cmd_i.align_shift;
  // a full window is never left at rest, but wrap like a fresh frame if it is
  assign wr_idx = fill_q[IdxW] ? '0 : fill_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (append) begin
      win_q[wr_idx] <= in_byte_i;
    end else if (shift) begin
      for (int j = 0; j < FrameBytes - 1; j++) begin
        win_q[j] <= win_q[j+1];
      end
    end
  end

  // captured time, CRC
  logic [31:0]     now_q;
  logic [7:0]      crc_q;
  logic [IdxW-1:0] crc_cnt_q;
  logic [IdxW-1:0] crc_idx;

  assign crc_idx = crc_cnt_q + IdxW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= '0;
      crc_cnt_q <= '0;
    end else if (cmd_i.capture) begin
      crc_q     <= '0;
      crc_cnt_q <= '0;
    end else if (cmd_i.crc_step) begin
      crc_q     <= crc8_byte(crc_q ^ win_q[crc_idx]);
      crc_cnt_q <= crc_cnt_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q <= in_now_i;
    end
  end

  // frame checks
  logic [7:0] f_ver, f_seq, f_ph, f_pay, f_st, f_crc, ph_mask;
  err_e       err;

  assign f_ver   = win_q[2];
  assign f_seq   = win_q[3];
  assign f_ph    = win_q[4];
  assign f_pay   = win_q[5];
  assign f_st    = win_q[6];
  assign f_crc   = win_q[7];
  assign ph_mask = ph_masks_q[{f_ph[1:0], 3'b000} +: 8];

  always_comb begin
    if (crc_q != f_crc) begin
      err = ErrCrc;
    end else if (f_ver != version_q) begin
      err = ErrVersion;
    end else if (f_ph >= 8'(PhaseCount)) begin
      err = ErrPhase;
    end else if (((f_pay & ph_mask) != '0) || ((f_st & st_mask_q) != '0)) begin
      err = ErrReserved;
    end else begin
      err = ErrNone;
    end
  end

  // link state
  logic [7:0]  last_seq_q;
  logic        seq_known_q;
  logic        link_q;
  logic [31:0] last_time_q;
  logic [31:0] elapsed;
  logic        expire;
  logic        frame_ok;
  logic        is_dup;

  assign elapsed  = now_q - last_time_q;
  assign expire   = cmd_i.tick && link_q && (elapsed >= timeout_q);
  assign frame_ok = cmd_i.eval && (err == ErrNone);
  assign is_dup   = seq_known_q && (f_seq == last_seq_q);

  always_comb begin
    fill_d = fill_q;
    if (append) begin
      fill_d = fill_q[IdxW] ? FillW'(1) : fill_q + FillW'(1);
    end else if (expire || frame_ok) begin
      fill_d = '0;
    end else if (shift) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      last_seq_q  <= '0;
      seq_known_q <= 1'b0;
      link_q      <= 1'b0;
      last_time_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (expire) begin
        link_q      <= 1'b0;
        seq_known_q <= 1'b0;
      end else if (frame_ok && !is_dup) begin
        last_seq_q  <= f_seq;
        seq_known_q <= 1'b1;
        last_time_q <= now_q;
        link_q      <= 1'b1;
      end
    end
  end

  // per-word result
  err_e       res_err_q;
  logic       res_acc_q, res_dup_q, res_lost_q;
  logic [7:0] res_seq_q, res_pay_q, res_st_q;
  logic [1:0] res_ph_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_err_q  <= ErrNone;
      res_acc_q  <= 1'b0;
      res_dup_q  <= 1'b0;
      res_lost_q <= 1'b0;
      res_seq_q  <= '0;
      res_ph_q   <= '0;
      res_pay_q  <= '0;
      res_st_q   <= '0;
    end else if (expire) begin
      res_lost_q <= 1'b1;
    end else if (cmd_i.eval) begin
      res_err_q <= err;
      if (err == ErrNone) begin
        res_seq_q <= f_seq;
        if (is_dup) begin
          res_dup_q <= 1'b1;
        end else begin
          res_acc_q <= 1'b1;
          res_ph_q  <= f_ph[1:0];
          res_pay_q <= f_pay;
          res_st_q  <= f_st;
        end
      end
    end
  end

  // output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_data_q <= {7'd0, link_q, res_lost_q, res_st_q, res_pay_q, res_ph_q,
                     res_seq_q, res_dup_q, res_acc_q, res_err_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // status
  assign status_o.full       = fill_q[IdxW];
  assign status_o.marker_ok  = (win_q[0] == sof1) && (win_q[1] == sof2);
  assign status_o.align_done = (fill_q == '0) || (win_q[0] == sof1);
  assign status_o.crc_last   = (crc_cnt_q == IdxW'(4));
  assign status_o.frame_bad  = (err != ErrNone);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ----- hw/rtl/crc8_frame_receiver_link_watchdog.sv -----
// Top level of the CRC-8 framed serial receiver with link watchdog.
//
//  channel  | direction | signals                          | contents
//  ---------+-----------+----------------------------------+---------------------------------
//  s_axis   | in        | tvalid tready tdata[39:0] tuser  | byte word or watchdog tick
//  m_axis   | out       | tvalid tready tdata[39:0]        | one result word per input word
//  cfg      | in        | valid ready index[2:0] data[31:0]| register writes, always ready
//
// A tick runs the watchdog check; a byte while collecting is appended and then head bytes
// are dropped in the resync scan until the window is empty or opens with the first sync byte;
// a full frame is CRC-checked and judged, then rescanned when rejected, as is a full window without the sync pair.
// The CRC unit and the window shifter each handle one byte per cycle.
// Reset empties the window, forgets the sequence and drops the link.
// A stalled result stays in the output register while the next word is taken.
module crc8_frame_receiver_link_watchdog
  import crc8rx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // byte_value[7:0], now_ms[39:8]
  input  logic                s_axis_tuser,  // opcode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // error_code[2:0], frame_accepted[3], duplicate[4], seq_number[12:5],
  // phase_code[14:13], payload_byte[22:15], status_byte[30:23], link_lost[31],
  // link_up[32], zero[39:33]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  crc8rx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_tick_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  crc8rx_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_tick_i   (s_axis_tuser),
    .in_byte_i   (s_axis_tdata[7:0]),
    .in_now_i    (s_axis_tdata[39:8]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ----- hw/rtl/crc8rx_checker.sv -----
// Port-level checks for the frame receiver, bound to the top level.
module crc8rx_checker
  import crc8rx_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic [2:0] err;
  logic       acc, dup, lost, up;

  assign err  = m_axis_tdata[2:0];
  assign acc  = m_axis_tdata[3];
  assign dup  = m_axis_tdata[4];
  assign lost = m_axis_tdata[31];
  assign up   = m_axis_tdata[32];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_acc_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(acc && dup))
    else $error("word both accepted and duplicate");

  a_acc_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && acc |-> (err == ErrNone) && up)
    else $error("accepted frame without clean status or link");

  a_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && lost |-> !up && (err == ErrNone) && !acc && !dup)
    else $error("link loss word inconsistent");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (err != ErrNone) |-> !acc && !dup && (err <= ErrReserved))
    else $error("error word malformed");

endmodule

bind crc8_frame_receiver_link_watchdog crc8rx_checker u_crc8rx_checker (.*);
